// File: rtl/sscu_pkg.sv
// Shared types, constants and coefficient helpers for the state-space controller.
// Depends on nothing; every other file in rtl/ imports it.
package sscu_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int DATA_W            = 32;
    localparam int NUM_STATES        = 4;
    localparam int NUM_GAINS         = 4;
    localparam int PROD_W            = 2 * DATA_W;
    // six products per row at most, three guard bits
    localparam int ACC_W             = PROD_W + 3;

    // coefficients are held as decimal values at scale 1e11
    localparam longint SCALE_DEC = 64'sd100000000000;

    // register indexes of the configuration port
    localparam logic [1:0] REG_GAIN_POSITION   = 2'd0;
    localparam logic [1:0] REG_GAIN_VELOCITY   = 2'd1;
    localparam logic [1:0] REG_GAIN_ANGLE      = 2'd2;
    localparam logic [1:0] REG_GAIN_ANGLE_RATE = 2'd3;

    // reset values of the output gains
    localparam logic signed [DATA_W-1:0] GAIN_POSITION_RST   = 32'sd64997;
    localparam logic signed [DATA_W-1:0] GAIN_VELOCITY_RST   = 32'sd367082;
    localparam logic signed [DATA_W-1:0] GAIN_ANGLE_RST      = -32'sd10082948;
    localparam logic signed [DATA_W-1:0] GAIN_ANGLE_RATE_RST = -32'sd4038007;

    // group codes: rows 0..3 build the new state, the last group the drive output
    localparam logic [2:0] GRP_OUT  = 3'd4;
    localparam logic [2:0] COL_LAST_ROW = 3'd5;
    localparam logic [2:0] COL_LAST_OUT = 3'd3;

    // one multiply-accumulate term issued by the sequencer
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [2:0] row;
        logic [2:0] col;
    } term_t;

    // a finished, rounded sum leaving the MAC
    typedef struct packed {
        logic                     valid;
        logic [2:0]               grp;
        logic                     sat;
        logic signed [DATA_W-1:0] value;
    } mac_res_t;

    // decimal coefficient of row r; columns 0..3 are A, columns 4..5 are B
    function automatic longint coef_dec(input int r, input int c);
        longint v;
        v = 0;
        case ({r[1:0], c[2:0]})
            {2'd0, 3'd0}: v = -64'sd127182176;
            {2'd0, 3'd1}: v = 64'sd166709062;
            {2'd0, 3'd2}: v = 64'sd3942352;
            {2'd0, 3'd3}: v = -64'sd3413921;
            {2'd0, 3'd4}: v = 64'sd100127237023;
            {2'd0, 3'd5}: v = -64'sd11916307;
            {2'd1, 3'd0}: v = -64'sd82232571057;
            {2'd1, 3'd1}: v = 64'sd100168353944;
            {2'd1, 3'd2}: v = -64'sd2736960051;
            {2'd1, 3'd3}: v = -64'sd4111431070;
            {2'd1, 3'd4}: v = 64'sd82298424086;
            {2'd1, 3'd5}: v = -64'sd6837212200;
            {2'd2, 3'd0}: v = 64'sd12477765;
            {2'd2, 3'd1}: v = 64'sd146087;
            {2'd2, 3'd2}: v = -64'sd119350985;
            {2'd2, 3'd3}: v = 64'sd164714635;
            {2'd2, 3'd4}: v = -64'sd12450749;
            {2'd2, 3'd5}: v = 64'sd100116763498;
            {2'd3, 3'd0}: v = 64'sd7511231093;
            {2'd3, 3'd1}: v = 64'sd162927913;
            {2'd3, 3'd2}: v = -64'sd80075105074;
            {2'd3, 3'd3}: v = 64'sd97761952609;
            {2'd3, 3'd4}: v = -64'sd7478799416;
            {2'd3, 3'd5}: v = 64'sd76969081941;
            default:      v = 0;
        endcase
        return v;
    endfunction

    // round a decimal coefficient half away from zero to frac fraction bits
    function automatic longint fixed_coef(input longint dec, input int frac);
        longint mag;
        longint q;
        mag = (dec < 0) ? -dec : dec;
        q   = (mag * (64'sd1 <<< frac) + SCALE_DEC / 2) / SCALE_DEC;
        return (dec < 0) ? -q : q;
    endfunction

endpackage

// File: rtl/state_space_observer_controller_unit.sv
// Top level of the four-state discrete controller: registers, state and handshakes.
// Depends on sscu_pkg, sscu_seq and sscu_mac.

// Each input transaction (cart position and angle error, Q16.16) updates the
// four-element state as x' = A*x + B*y, every row reading the old state, and
// returns one result: the drive value C*x' with a flag that is set when any
// state element or the drive value saturated. All 28 products go through one
// 32x32 multiplier and one accumulator, one product per cycle; a sample
// occupies the block from acceptance until its last term has left the multiply
// and accumulate stages, so a new transaction is taken only once the last one is
// through. A finished result waits in a one-entry holding register when the
// output side stalls, and the next sample is then accepted only once that entry
// has moved to the output. The user is to write gains through cfg_we, cfg_index
// and cfg_data only while no sample is in flight; the block does not enforce it.
module state_space_observer_controller_unit #(
    parameter int FRAC_BITS = sscu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [sscu_pkg::DATA_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [sscu_pkg::DATA_W-1:0] measured_position,
    input  logic signed [sscu_pkg::DATA_W-1:0] angle_error,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [sscu_pkg::DATA_W-1:0] drive_force,
    output logic                               clipped
);
    import sscu_pkg::*;

    localparam int CW = FRAC_BITS + 4;

    logic signed [CW-1:0]     coef_tab [NUM_STATES][6];
    logic signed [DATA_W-1:0] gain_reg [NUM_GAINS];
    logic signed [DATA_W-1:0] x_reg [NUM_STATES];
    logic signed [DATA_W-1:0] nx_reg [NUM_STATES];
    logic signed [DATA_W-1:0] y_reg [2];
    logic                     clip_reg;
    logic signed [DATA_W-1:0] pend_value_reg;
    logic                     pend_clip_reg;
    logic                     pend_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_clip_reg;
    logic                     out_valid_reg;

    logic                     seq_idle;
    logic                     in_fire;
    term_t                    term;
    mac_res_t                 res;
    logic signed [DATA_W-1:0] op_a, op_b;
    logic                     fin;
    logic                     fin_clip;
    logic                     out_free;

    // fixed A and B coefficients, rounded at elaboration
    for (genvar r = 0; r < NUM_STATES; r++)
    begin : g_row
        for (genvar c = 0; c < 6; c++)
        begin : g_col
            assign coef_tab[r][c] = CW'(fixed_coef(coef_dec(r, c), FRAC_BITS));
        end
    end

    assign in_ready = seq_idle & ~pend_valid_reg;
    assign in_fire  = in_valid & in_ready;

    sscu_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire),
        .idle  (seq_idle),
        .term  (term)
    );

    // select the operands of the current term
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (term.row == GRP_OUT)
        begin
            op_a = gain_reg[term.col[1:0]];
            op_b = nx_reg[term.col[1:0]];
        end
        else
        begin
            op_b = DATA_W'(coef_tab[term.row[1:0]][term.col]);
            if (term.col[2])
            begin
                op_a = y_reg[term.col[0]];
            end
            else
            begin
                op_a = x_reg[term.col[1:0]];
            end
        end
    end

    sscu_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .term  (term),
        .op_a  (op_a),
        .op_b  (op_b),
        .res   (res)
    );

    assign fin      = res.valid & (res.grp == GRP_OUT);
    assign fin_clip = clip_reg | res.sat;
    assign out_free = ~out_valid_reg | out_ready;

    // write the output gains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[REG_GAIN_POSITION]   <= GAIN_POSITION_RST;
            gain_reg[REG_GAIN_VELOCITY]   <= GAIN_VELOCITY_RST;
            gain_reg[REG_GAIN_ANGLE]      <= GAIN_ANGLE_RST;
            gain_reg[REG_GAIN_ANGLE_RATE] <= GAIN_ANGLE_RATE_RST;
        end
        else if (cfg_we)
        begin
            gain_reg[cfg_index] <= cfg_data;
        end
    end

    // capture the sample on acceptance
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            y_reg[0] <= measured_position;
            y_reg[1] <= angle_error;
        end
    end

    // collect the new state rows as they leave the MAC
    always_ff @(posedge clk)
    begin
        if (res.valid && (res.grp != GRP_OUT))
        begin
            nx_reg[res.grp[1:0]] <= res.value;
        end
    end

    // commit the new state once the drive value is done; track saturation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                x_reg[i] <= '0;
            end
            clip_reg <= 1'b0;
        end
        else
        begin
            if (fin)
            begin
                for (int i = 0; i < NUM_STATES; i++)
                begin
                    x_reg[i] <= nx_reg[i];
                end
            end
            if (in_fire)
            begin
                clip_reg <= 1'b0;
            end
            else if (res.valid)
            begin
                clip_reg <= fin_clip;
            end
        end
    end

    // hold a finished result when the output is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (fin && !out_free)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin && !out_free)
        begin
            pend_value_reg <= res.value;
            pend_clip_reg  <= fin_clip;
        end
    end

    // load the output register from a fresh result or the held one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fin | pend_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (fin)
            begin
                out_value_reg <= res.value;
                out_clip_reg  <= fin_clip;
            end
            else if (pend_valid_reg)
            begin
                out_value_reg <= pend_value_reg;
                out_clip_reg  <= pend_clip_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_force = out_value_reg;
    assign clipped     = out_clip_reg;

endmodule

// File: rtl/sscu_seq.sv
// Sequencer: walks the 28 multiply-accumulate terms of one sample in order.
// Depends on sscu_pkg (term_t, group and column codes).
module sscu_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           idle,
    output sscu_pkg::term_t term
);
    import sscu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] row_reg, row_next;
    logic [2:0] col_reg, col_next;
    logic       drain_reg, drain_next;
    logic       col_end;

    // last column of the current group
    assign col_end = (row_reg == GRP_OUT) ? (col_reg == COL_LAST_OUT)
                                          : (col_reg == COL_LAST_ROW);

    // advance through rows and columns, then wait for the pipe to empty
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_ISSUE;
                    row_next   = 3'd0;
                    col_next   = 3'd0;
                end
            end
            ST_ISSUE:
            begin
                if (col_end)
                begin
                    col_next = 3'd0;
                    if (row_reg == GRP_OUT)
                    begin
                        state_next = ST_DRAIN;
                        drain_next = 1'b0;
                    end
                    else
                    begin
                        row_next = row_reg + 3'd1;
                    end
                end
                else
                begin
                    col_next = col_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= 3'd0;
            col_reg   <= 3'd0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
        end
    end

    // describe the term issued this cycle
    always_comb
    begin
        term.valid = (state_reg == ST_ISSUE);
        term.first = (col_reg == 3'd0);
        term.last  = col_end;
        term.row   = row_reg;
        term.col   = col_reg;
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

// File: rtl/sscu_mac.sv
// Shared multiply-accumulate unit with round-half-up and 32-bit saturation.
// Depends on sscu_pkg (term_t, mac_res_t, widths).
module sscu_mac #(
    parameter int FRAC_BITS = sscu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sscu_pkg::term_t                   term,
    input  logic signed [sscu_pkg::DATA_W-1:0] op_a,
    input  logic signed [sscu_pkg::DATA_W-1:0] op_b,
    output sscu_pkg::mac_res_t                res
);
    import sscu_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic                     p_valid_reg, p_first_reg, p_last_reg;
    logic [2:0]               p_grp_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     a_last_reg;
    logic [2:0]               a_grp_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  shifted;

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_first_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            p_grp_reg   <= 3'd0;
        end
        else
        begin
            p_valid_reg <= term.valid;
            p_first_reg <= term.first;
            p_last_reg  <= term.last;
            p_grp_reg   <= term.row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (term.valid)
        begin
            prod_reg <= PROD_W'(op_a * op_b);
        end
    end

    // accumulate stage: restart on the first term of a group
    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next = p_first_reg ? prod_ext : (acc_reg + prod_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_last_reg <= 1'b0;
            a_grp_reg  <= 3'd0;
        end
        else
        begin
            a_last_reg <= p_valid_reg & p_last_reg;
            a_grp_reg  <= p_grp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // round half up, drop fraction bits, clamp to 32 bits
    assign rounded = acc_reg + HALF;
    assign shifted = rounded >>> FRAC_BITS;

    always_comb
    begin
        res.valid = a_last_reg;
        res.grp   = a_grp_reg;
        if (shifted > SAT_MAX)
        begin
            res.sat   = 1'b1;
            res.value = SAT_MAX[DATA_W-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            res.sat   = 1'b1;
            res.value = SAT_MIN[DATA_W-1:0];
        end
        else
        begin
            res.sat   = 1'b0;
            res.value = shifted[DATA_W-1:0];
        end
    end

endmodule

// File: tb/state_space_observer_controller_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for state_space_observer_controller_unit: directed samples, then
// random phases with gain changes, idle/stall patterns and a long output hold-off.
// Depends on sscu_pkg and the RTL of the controller unit.
module state_space_observer_controller_unit_tb;
    import sscu_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int FRAC            = FRAC_BITS_DEFAULT;
    localparam int WIDE            = 72;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 50;

    localparam logic signed [WIDE-1:0] ROUND_HALF = 72'sd1 <<< (FRAC - 1);
    localparam logic signed [WIDE-1:0] SAT_HI     = 72'sd2147483647;
    localparam logic signed [WIDE-1:0] SAT_LO     = -72'sd2147483648;
    localparam logic signed [31:0]     Q_MAX      = 32'sh7FFFFFFF;
    localparam logic signed [31:0]     Q_MIN      = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clip;
    } drive_result_t;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] ang;
        logic               has_result;
        drive_result_t      result;
    } stim_row_t;

    logic                     clk               = 1'b0;
    logic                     rst_n             = 1'b0;
    logic                     cfg_we            = 1'b0;
    logic [1:0]               cfg_index         = REG_GAIN_POSITION;
    logic [DATA_W-1:0]        cfg_data          = '0;
    logic                     in_valid          = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] measured_position = '0;
    logic signed [DATA_W-1:0] angle_error       = '0;
    logic                     out_valid;
    logic                     out_ready         = 1'b0;
    logic signed [DATA_W-1:0] drive_force;
    logic                     clipped;

    // predictor copy of the observer state and output gains
    logic signed [31:0] est_state [4];
    logic signed [31:0] out_gain [4];

    drive_result_t expected_drive_q [$];
    drive_result_t head_result;
    stim_row_t     stim_table [$];

    int mismatch_count     = 0;
    int results_seen       = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int holds_requested    = 0;
    int holds_served       = 0;
    int hold_left          = 0;
    int quiet_cycles       = 0;

    state_space_observer_controller_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .measured_position (measured_position),
        .angle_error       (angle_error),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .drive_force       (drive_force),
        .clipped           (clipped)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // A and B coefficients at scale 1e11, rounded half away from zero to FRAC bits;
    // columns 0..3 weight the state, 4..5 the two measurements
    function automatic longint coef_q16(input int row, input int col);
        longint e11;
        longint mag;
        longint q;
        case (row * 6 + col)
            0:  e11 = -64'sd127182176;
            1:  e11 = 64'sd166709062;
            2:  e11 = 64'sd3942352;
            3:  e11 = -64'sd3413921;
            4:  e11 = 64'sd100127237023;
            5:  e11 = -64'sd11916307;
            6:  e11 = -64'sd82232571057;
            7:  e11 = 64'sd100168353944;
            8:  e11 = -64'sd2736960051;
            9:  e11 = -64'sd4111431070;
            10: e11 = 64'sd82298424086;
            11: e11 = -64'sd6837212200;
            12: e11 = 64'sd12477765;
            13: e11 = 64'sd146087;
            14: e11 = -64'sd119350985;
            15: e11 = 64'sd164714635;
            16: e11 = -64'sd12450749;
            17: e11 = 64'sd100116763498;
            18: e11 = 64'sd7511231093;
            19: e11 = 64'sd162927913;
            20: e11 = -64'sd80075105074;
            21: e11 = 64'sd97761952609;
            22: e11 = -64'sd7478799416;
            23: e11 = 64'sd76969081941;
            default: e11 = 0;
        endcase
        mag = (e11 < 0) ? -e11 : e11;
        q   = (mag * (64'sd1 <<< FRAC) + 64'sd50000000000) / 64'sd100000000000;
        return (e11 < 0) ? -q : q;
    endfunction

    // round half up to FRAC bits, then clamp to 32 bits; top bit flags saturation
    function automatic logic [32:0] round_sat(input logic signed [WIDE-1:0] sum);
        logic signed [WIDE-1:0] q;
        q = (sum + ROUND_HALF) >>> FRAC;
        if (q > SAT_HI)
            return {1'b1, Q_MAX};
        if (q < SAT_LO)
            return {1'b1, Q_MIN};
        return {1'b0, q[31:0]};
    endfunction

    // x' = A*x + B*y from the old state, then drive = C*x'
    function automatic drive_result_t advance_controller(input logic signed [31:0] pos,
                                                         input logic signed [31:0] ang);
        logic signed [WIDE-1:0] sum;
        logic signed [WIDE-1:0] c;
        logic signed [31:0]     opnd [6];
        logic signed [31:0]     next_x [4];
        logic [32:0]            rs;
        drive_result_t          r;
        r.clip = 1'b0;
        for (int k = 0; k < 4; k++)
            opnd[k] = est_state[k];
        opnd[4] = pos;
        opnd[5] = ang;
        for (int row = 0; row < 4; row++)
        begin
            sum = '0;
            for (int col = 0; col < 6; col++)
            begin
                c   = coef_q16(row, col);
                sum = sum + c * opnd[col];
            end
            rs          = round_sat(sum);
            next_x[row] = rs[31:0];
            r.clip      = r.clip | rs[32];
        end
        sum = '0;
        for (int k = 0; k < 4; k++)
        begin
            est_state[k] = next_x[k];
            c            = out_gain[k];
            sum          = sum + c * next_x[k];
        end
        rs      = round_sat(sum);
        r.drive = rs[31:0];
        r.clip  = r.clip | rs[32];
        return r;
    endfunction

    // random value sign-extended from its low bits
    function automatic logic signed [31:0] rand_signed(input int bits);
        logic signed [31:0] t;
        t = $urandom << (32 - bits);
        return t >>> (32 - bits);
    endfunction

    // mostly realistic magnitudes, some wide, some full range, some zero to let the state decay
    function automatic logic signed [31:0] random_field();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return rand_signed(18);
        if (pick < 8)
            return rand_signed(26);
        if (pick < 9)
            return rand_signed(32);
        return '0;
    endfunction

    function automatic void add_row(input logic signed [31:0] pos, input logic signed [31:0] ang,
                                    input logic has_result, input logic signed [31:0] drive,
                                    input logic clip);
        stim_row_t row;
        row.pos          = pos;
        row.ang          = ang;
        row.has_result   = has_result;
        row.result.drive = drive;
        row.result.clip  = clip;
        stim_table.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // keep the log short when everything goes wrong
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    // offer one sample, hold it until accepted, then queue its expected result
    task automatic offer_sample(input logic signed [31:0] pos, input logic signed [31:0] ang,
                                input logic use_row, input drive_result_t row_result);
        int            gap;
        drive_result_t predicted;
        gap = 0;
        if (sender_idle_pct != 0)
        begin
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(1, 40);
            else
                while ($urandom_range(0, 99) < sender_idle_pct)
                    gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        measured_position <= pos;
        angle_error       <= ang;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_controller(pos, ang);
        expected_drive_q.push_back(use_row ? row_result : predicted);
    endtask

    task automatic write_gains(input logic signed [31:0] g_pos, input logic signed [31:0] g_vel,
                               input logic signed [31:0] g_ang, input logic signed [31:0] g_rate);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAIN_POSITION;
        cfg_data  <= g_pos;
        @(posedge clk);
        cfg_index <= REG_GAIN_VELOCITY;
        cfg_data  <= g_vel;
        @(posedge clk);
        cfg_index <= REG_GAIN_ANGLE;
        cfg_data  <= g_ang;
        @(posedge clk);
        cfg_index <= REG_GAIN_ANGLE_RATE;
        cfg_data  <= g_rate;
        @(posedge clk);
        cfg_we <= 1'b0;
        out_gain[REG_GAIN_POSITION]   = g_pos;
        out_gain[REG_GAIN_VELOCITY]   = g_vel;
        out_gain[REG_GAIN_ANGLE]      = g_ang;
        out_gain[REG_GAIN_ANGLE_RATE] = g_rate;
    endtask

    task automatic wait_drained();
        while (expected_drive_q.size() != 0)
            @(posedge clk);
    endtask

    // check each result transaction, then drive ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_drive_q.size() == 0)
                report_mismatch($sformatf("drive_force=%0d clipped=%0b with nothing pending",
                                          drive_force, clipped));
            else
            begin
                head_result = expected_drive_q.pop_front();
                if (drive_force !== head_result.drive)
                    report_mismatch($sformatf("drive_force expected %0d got %0d",
                                              head_result.drive, drive_force));
                if (clipped !== head_result.clip)
                    report_mismatch($sformatf("clipped expected %0b got %0b",
                                              head_result.clip, clipped));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_served != holds_requested)
        begin
            // long hold-off: let the block fill up and stall its input
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // abort when no transaction moves on either side for too long
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else if (rst_n)
                quiet_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        drive_result_t none;
        none = '0;
        for (int k = 0; k < 4; k++)
            est_state[k] = '0;
        out_gain[REG_GAIN_POSITION]   = GAIN_POSITION_RST;
        out_gain[REG_GAIN_VELOCITY]   = GAIN_VELOCITY_RST;
        out_gain[REG_GAIN_ANGLE]      = GAIN_ANGLE_RST;
        out_gain[REG_GAIN_ANGLE_RATE] = GAIN_ANGLE_RATE_RST;

        // zero state and zero input give zero drive
        add_row(32'sh0, 32'sh0, 1'b1, 32'sh0, 1'b0);
        add_row(32'sh0, 32'sh0, 1'b1, 32'sh0, 1'b0);
        // full-scale position from zero state: first state element and drive both saturate
        add_row(Q_MAX, 32'sh0, 1'b1, Q_MAX, 1'b1);
        add_row(Q_MIN, 32'sh0, 1'b0, '0, 1'b0);
        add_row(32'sh0, Q_MAX, 1'b0, '0, 1'b0);
        add_row(32'sh0, Q_MIN, 1'b0, '0, 1'b0);
        add_row(Q_MAX, Q_MAX, 1'b0, '0, 1'b0);
        add_row(Q_MIN, Q_MIN, 1'b0, '0, 1'b0);
        add_row(Q_MAX, Q_MIN, 1'b0, '0, 1'b0);
        add_row(32'sh1, -32'sh1, 1'b0, '0, 1'b0);
        add_row(-32'sh1, 32'sh1, 1'b0, '0, 1'b0);
        add_row(32'shAAAAAAAA, 32'sh55555555, 1'b0, '0, 1'b0);
        add_row(32'sh55555555, 32'shAAAAAAAA, 1'b0, '0, 1'b0);
        // let a saturated state decay
        add_row(32'sh0, 32'sh0, 1'b0, '0, 1'b0);
        add_row(32'sh0, 32'sh0, 1'b0, '0, 1'b0);
        add_row(32'sh0, 32'sh0, 1'b0, '0, 1'b0);
        add_row(32'sh00010000, 32'sh0, 1'b0, '0, 1'b0);
        add_row(32'sh0, 32'sh0000199A, 1'b0, '0, 1'b0);
        add_row(32'shFFFF0000, 32'sh0000FFFF, 1'b0, '0, 1'b0);
        add_row(32'sh0, 32'sh0, 1'b0, '0, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples under reset gains, no idling
        foreach (stim_table[k])
            offer_sample(stim_table[k].pos, stim_table[k].ang, stim_table[k].has_result,
                         stim_table[k].result);

        for (int ph = 1; ph <= NUM_PHASES; ph++)
        begin
            in_valid <= 1'b0;
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (ph)
                1: write_gains(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
                2: write_gains(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
                3: write_gains('0, '0, '0, '0);
                4: write_gains(rand_signed(22), rand_signed(22), rand_signed(22),
                               rand_signed(22));
                5: write_gains(GAIN_POSITION_RST, GAIN_VELOCITY_RST, GAIN_ANGLE_RST,
                               GAIN_ANGLE_RATE_RST);
                default: write_gains(rand_signed(32), rand_signed(32), rand_signed(32),
                                     rand_signed(32));
            endcase
            // rotate idle patterns: sender, receiver, both, none
            case (ph % 4)
                1:
                begin
                    sender_idle_pct    = 67;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 67;
                end
                3:
                begin
                    sender_idle_pct    = 33;
                    receiver_stall_pct = 33;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            if (ph == PRESSURE_PHASE)
                holds_requested++;
            repeat (ITEMS_PER_PHASE)
                offer_sample(random_field(), random_field(), 1'b0, none);
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
rtl/sscu_pkg.sv
rtl/sscu_seq.sv
rtl/sscu_mac.sv
rtl/state_space_observer_controller_unit.sv
tb/state_space_observer_controller_unit_tb.sv
